// ===== rtl/core/lsb_stego_stream_decoder_defines.svh =====
// Assertion macros used by the decoder's result queue RTL.
`ifndef LSB_STEGO_STREAM_DECODER_DEFINES_SVH
`define LSB_STEGO_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define LSSD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lssd assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define LSSD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lssd assertion failed");

`endif

// ===== rtl/core/lssd_pkg.sv =====
// Shared types and constants of the LSB stego stream decoder.
package lssd_pkg;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   localparam logic [CsrIdxW-1:0] CsrHeaderBytes   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrExpectedMagic = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrMagicCheckOn  = 2'd2;

   localparam logic [15:0] HeaderBytesReset = 16'd54;

   localparam logic [1:0] KindExt      = 2'd0;
   localparam logic [1:0] KindPay      = 2'd1;
   localparam logic [1:0] KindMismatch = 2'd2;
   localparam logic [1:0] KindEmpty    = 2'd3;

   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] kind;
      logic       last;
   } entry_type;

endpackage

// ===== rtl/core/lsb_stego_stream_decoder.sv =====
// An item's result is written to the result queue on its transfer, then offered on rsp_.
// Throughput: one carrier byte per cycle while the result queue is not full.
// req_ready drops only while the four-entry result queue is full.
// Reset is synchronous, active high: parse restarts in header skip with no bytes to skip,
// queue empties, registers return to header_bytes 54, expected_magic 0, magic_check_on 1.
module lsb_stego_stream_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [lssd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [lssd_pkg::CsrDataW-1:0]  csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_carrier_byte,
   input  logic                           req_start_of_image,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_data_byte,
   output logic [1:0]                     rsp_kind,
   output logic                           rsp_last
);
   import lssd_pkg::*;

   logic      accept;
   logic      push;
   logic      full;
   entry_type push_entry;
   entry_type rsp_entry;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   lssd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .carrier_byte     (req_carrier_byte),
      .start_of_image   (req_start_of_image),
      .push             (push),
      .push_entry       (push_entry)
   );

   lssd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_entry  (rsp_entry)
   );

   assign rsp_data_byte = rsp_entry.data_byte;
   assign rsp_kind      = rsp_entry.kind;
   assign rsp_last      = rsp_entry.last;

endmodule

// ===== rtl/core/lssd_front.sv =====
// Front end: config registers, bit gatherer and stream parser.
module lssd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [lssd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [lssd_pkg::CsrDataW-1:0]  csr_write_data,
   input  logic                           accept,
   input  logic [7:0]                     carrier_byte,
   input  logic                           start_of_image,
   output logic                           push,
   output lssd_pkg::entry_type            push_entry
);
   import lssd_pkg::*;

   localparam logic [2:0] PhHeader  = 3'd0;
   localparam logic [2:0] PhMagic   = 3'd1;
   localparam logic [2:0] PhExtLen  = 3'd2;
   localparam logic [2:0] PhExtData = 3'd3;
   localparam logic [2:0] PhPayLen  = 3'd4;
   localparam logic [2:0] PhPayData = 3'd5;
   localparam logic [2:0] PhIdle    = 3'd6;

   logic [15:0] header_bytes_ff;
   logic [15:0] expected_magic_ff;
   logic        magic_check_on_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] header_left_ff, header_left_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [31:0] gather_ff, gather_in;
   logic [31:0] bytes_left_ff, bytes_left_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff   <= HeaderBytesReset;
         expected_magic_ff <= '0;
         magic_check_on_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrHeaderBytes:   header_bytes_ff   <= csr_write_data;
            CsrExpectedMagic: expected_magic_ff <= csr_write_data;
            CsrMagicCheckOn:  magic_check_on_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [2:0]  ph;
      logic [15:0] hl;
      logic [4:0]  bc;
      logic [31:0] gs;
      logic [31:0] bl;
      logic [31:0] gs_new;
      logic [5:0]  bc_inc;
      logic [5:0]  need;
      phase_in       = phase_ff;
      header_left_in = header_left_ff;
      bit_count_in   = bit_count_ff;
      gather_in      = gather_ff;
      bytes_left_in  = bytes_left_ff;
      push           = 1'b0;
      push_entry     = '{data_byte: 8'd0, kind: KindExt, last: 1'b0};
      gs_new         = '0;
      bc_inc         = '0;
      need           = '0;

      // restart the parse on start of image
      ph = start_of_image ? PhHeader        : phase_ff;
      hl = start_of_image ? header_bytes_ff : header_left_ff;
      bc = start_of_image ? 5'd0            : bit_count_ff;
      gs = start_of_image ? 32'd0           : gather_ff;
      bl = start_of_image ? 32'd0           : bytes_left_ff;

      if (ph < PhIdle) begin
         if (ph == PhHeader && hl != 16'd0) begin
            hl = hl - 16'd1;
         end else begin
            if (ph == PhHeader) begin
               ph = PhMagic;
               bc = 5'd0;
               gs = 32'd0;
            end
            gs_new = {gs[30:0], carrier_byte[0]};
            bc_inc = {1'b0, bc} + 6'd1;
            unique case (ph)
               PhMagic:            need = 6'd16;
               PhExtLen, PhPayLen: need = 6'd32;
               default:            need = 6'd8;
            endcase
            if (bc_inc < need) begin
               bc = bc_inc[4:0];
               gs = gs_new;
            end else begin
               bc = 5'd0;
               gs = 32'd0;
               unique case (ph)
                  PhMagic: begin
                     if (magic_check_on_ff && gs_new[15:0] != expected_magic_ff) begin
                        ph   = PhIdle;
                        push = 1'b1;
                        push_entry = '{data_byte: 8'd0, kind: KindMismatch, last: 1'b1};
                     end else begin
                        ph = PhExtLen;
                     end
                  end
                  PhExtLen: begin
                     bl = gs_new;
                     ph = (gs_new == 32'd0) ? PhPayLen : PhExtData;
                  end
                  PhExtData: begin
                     bl = bl - 32'd1;
                     if (bl == 32'd0) ph = PhPayLen;
                     push = 1'b1;
                     push_entry = '{data_byte: gs_new[7:0], kind: KindExt, last: 1'b0};
                  end
                  PhPayLen: begin
                     bl = gs_new;
                     if (gs_new == 32'd0) begin
                        ph   = PhIdle;
                        push = 1'b1;
                        push_entry = '{data_byte: 8'd0, kind: KindEmpty, last: 1'b1};
                     end else begin
                        ph = PhPayData;
                     end
                  end
                  default: begin
                     bl = bl - 32'd1;
                     push = 1'b1;
                     push_entry = '{data_byte: gs_new[7:0], kind: KindPay, last: 1'b0};
                     if (bl == 32'd0) begin
                        ph = PhIdle;
                        push_entry.last = 1'b1;
                     end
                  end
               endcase
            end
         end
      end

      if (accept) begin
         phase_in       = ph;
         header_left_in = hl;
         bit_count_in   = bc;
         gather_in      = gs;
         bytes_left_in  = bl;
      end else begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhHeader;
         header_left_ff <= '0;
         bit_count_ff   <= '0;
         gather_ff      <= '0;
         bytes_left_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         header_left_ff <= header_left_in;
         bit_count_ff   <= bit_count_in;
         gather_ff      <= gather_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

endmodule

// ===== rtl/core/lssd_fifo.sv =====
// Back end: result queue that parts the parser from the response channel.
`include "lsb_stego_stream_decoder_defines.svh"

module lssd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lssd_pkg::entry_type  push_entry,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lssd_pkg::entry_type  rsp_entry
);
   import lssd_pkg::*;

   entry_type            mem [FifoDepth];
   logic [FifoPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]  count_ff, count_in;
   logic                 pop;

   assign full      = (count_ff == FifoCntW'(FifoDepth));
   assign rsp_valid = (count_ff != '0);
   assign rsp_entry = mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FifoPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FifoPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + FifoCntW'(1);
      if (pop && !push) count_in = count_ff - FifoCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LSSD_ASSERT_NOW(a_no_push_when_full, !reset && push, !full)
   `LSSD_ASSERT_NEXT(a_pop_drains, !reset && pop && !push, count_ff == $past(count_ff) - FifoCntW'(1))
   `LSSD_ASSERT_NEXT(a_push_fills, !reset && push && !pop, count_ff == $past(count_ff) + FifoCntW'(1))

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the LSB stego stream decoder: directed images plus random traffic.
`timescale 1ns / 1ps

module tb_top;
   import lssd_pkg::*;

   localparam int unsigned CycleLimit   = 3_000_000;
   localparam int unsigned SettleCycles = 4;
   localparam int unsigned RandomItems  = 300;
   localparam int unsigned MaxReported  = 10;

   typedef enum logic [2:0] {
      PhHeader, PhMagic, PhExtLen, PhExtData, PhPayLen, PhPayData, PhIdle
   } parse_phase_type;

   typedef enum int {RspAlways, RspRandom, RspPattern} rsp_mode_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                csr_write_enable   = 1'b0;
   logic [CsrIdxW-1:0]  csr_index          = '0;
   logic [CsrDataW-1:0] csr_write_data     = '0;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [7:0]          req_carrier_byte   = '0;
   logic                req_start_of_image = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [7:0]          rsp_data_byte;
   logic [1:0]          rsp_kind;
   logic                rsp_last;

   // shadow of the block's registers and parse state
   logic [15:0]     cfg_header_bytes = HeaderBytesReset;
   logic [15:0]     cfg_magic        = '0;
   logic            cfg_check_on     = 1'b1;
   parse_phase_type dec_phase        = PhHeader;
   logic [15:0]     dec_header_left  = '0;
   logic [4:0]      dec_bit_count    = '0;
   logic [31:0]     dec_gather       = '0;
   logic [31:0]     dec_bytes_left   = '0;

   entry_type   decoded_q[$];
   int unsigned mismatches   = 0;
   int unsigned bytes_sent   = 0;
   int unsigned image_bytes  = 0;
   int unsigned images_sent  = 0;
   int unsigned csr_writes   = 0;
   int unsigned got_ext      = 0;
   int unsigned got_pay      = 0;
   int unsigned got_status   = 0;

   bit           gaps_on          = 1'b0;
   int unsigned  burst_left       = 0;
   bit           req_offered      = 1'b0;
   rsp_mode_type rsp_mode         = RspAlways;
   int unsigned  rsp_hold_request = 0;

   lsb_stego_stream_decoder DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_carrier_byte   (req_carrier_byte),
      .req_start_of_image (req_start_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_kind           (rsp_kind),
      .rsp_last           (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void queue_decoded(input logic [7:0] data, input logic [1:0] kind,
                                         input logic last);
      entry_type e;
      e.data_byte = data;
      e.kind      = kind;
      e.last      = last;
      decoded_q.push_back(e);
   endfunction

   // Advance the shadow decoder by one accepted carrier byte.
   task automatic decode_carrier(input logic [7:0] carrier, input logic sof);
      logic [31:0] word;
      int unsigned need;
      if (sof) begin
         dec_phase       = PhHeader;
         dec_header_left = cfg_header_bytes;
         dec_bit_count   = '0;
         dec_gather      = '0;
         dec_bytes_left  = '0;
      end
      if (dec_phase == PhIdle) return;
      if (dec_phase == PhHeader) begin
         if (dec_header_left != 0) begin
            dec_header_left = dec_header_left - 16'd1;
            return;
         end
         dec_phase     = PhMagic;
         dec_bit_count = '0;
         dec_gather    = '0;
      end
      dec_gather = {dec_gather[30:0], carrier[0]};
      if (dec_phase == PhMagic) need = 16;
      else if (dec_phase == PhExtLen || dec_phase == PhPayLen) need = 32;
      else need = 8;
      if (dec_bit_count + 1 < need) begin
         dec_bit_count = dec_bit_count + 5'd1;
         return;
      end
      dec_bit_count = '0;
      word          = dec_gather;
      dec_gather    = '0;
      case (dec_phase)
         PhMagic: begin
            if (cfg_check_on && word[15:0] != cfg_magic) begin
               dec_phase = PhIdle;
               queue_decoded(8'h00, KindMismatch, 1'b1);
            end else begin
               dec_phase = PhExtLen;
            end
         end
         PhExtLen: begin
            dec_bytes_left = word;
            dec_phase      = (word == 0) ? PhPayLen : PhExtData;
         end
         PhExtData: begin
            dec_bytes_left = dec_bytes_left - 1;
            if (dec_bytes_left == 0) dec_phase = PhPayLen;
            queue_decoded(word[7:0], KindExt, 1'b0);
         end
         PhPayLen: begin
            dec_bytes_left = word;
            if (word == 0) begin
               dec_phase = PhIdle;
               queue_decoded(8'h00, KindEmpty, 1'b1);
            end else begin
               dec_phase = PhPayData;
            end
         end
         default: begin
            dec_bytes_left = dec_bytes_left - 1;
            queue_decoded(word[7:0], KindPay, dec_bytes_left == 0);
            if (dec_bytes_left == 0) dec_phase = PhIdle;
         end
      endcase
   endtask

   task automatic drop_req();
      if (req_offered) begin
         req_valid   <= 1'b0;
         req_offered  = 1'b0;
      end
   endtask

   // Bursts of random length with random gaps in between.
   task automatic pace_sender();
      int unsigned gap;
      if (!gaps_on) return;
      if (burst_left != 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 6);
      drop_req();
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_carrier(input logic [7:0] carrier, input logic sof);
      req_valid          <= 1'b1;
      req_carrier_byte   <= carrier;
      req_start_of_image <= sof;
      req_offered         = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_carrier(carrier, sof);
      bytes_sent++;
      pace_sender();
   endtask

   // Hold off new items until every decoded result has been seen.
   task automatic wait_drained();
      drop_req();
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CsrHeaderBytes:   cfg_header_bytes = value;
         CsrExpectedMagic: cfg_magic        = value;
         CsrMagicCheckOn:  cfg_check_on     = value[0];
         default: ;
      endcase
      csr_writes++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_csrs(input logic [15:0] hdr, input logic [15:0] magic,
                               input logic check_on);
      write_csr(CsrHeaderBytes, hdr);
      write_csr(CsrExpectedMagic, magic);
      // upper bits of the check flag are don't-care
      write_csr(CsrMagicCheckOn, {15'($urandom), check_on});
   endtask

   function automatic void push_field(ref bit q[$], input logic [31:0] value, input int width);
      for (int i = width - 1; i >= 0; i--) q.push_back(value[i]);
   endfunction

   // Hidden bit stream of one image; stops after the extension when it is cut short.
   function automatic void build_stream(ref bit q[$], input logic [15:0] magic,
                                        input logic [31:0] ext_len, input int unsigned ext_sent,
                                        input logic [31:0] pay_len, input int unsigned pay_sent);
      q.delete();
      push_field(q, magic, 16);
      push_field(q, ext_len, 32);
      for (int unsigned i = 0; i < ext_sent; i++) push_field(q, 32'($urandom), 8);
      if (ext_sent != ext_len) return;
      push_field(q, pay_len, 32);
      for (int unsigned i = 0; i < pay_sent; i++) push_field(q, 32'($urandom), 8);
   endfunction

   task automatic send_stream(input int unsigned skip, input bit with_sof, ref bit q[$]);
      logic [7:0] carrier;
      if (with_sof) images_sent++;
      for (int unsigned i = 0; i < skip + q.size(); i++) begin
         carrier = 8'($urandom);
         if (i >= skip) carrier[0] = q[i - skip];
         send_carrier(carrier, with_sof && i == 0);
         image_bytes++;
      end
   endtask

   task automatic send_noise(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_carrier(8'($urandom), 1'b0);
   endtask

   // Receiver: long hold-offs on request, otherwise the current stall mode.
   initial begin : rsp_stall_gen
      int unsigned stretch;
      int unsigned pattern_pos;
      pattern_pos = 0;
      forever begin
         @(posedge clock);
         pattern_pos++;
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (rsp_hold_request != 0) begin
            stretch          = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_ready       <= 1'b0;
            repeat (stretch - 1) @(posedge clock);
         end else begin
            case (rsp_mode)
               RspRandom:  rsp_ready <= ($urandom_range(0, 99) < 65);
               RspPattern: rsp_ready <= (pattern_pos % 7) < 4;
               default:    rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("ERROR: unexpected result data %02h kind %0d last %0d",
                        rsp_data_byte, rsp_kind, rsp_last);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_data_byte !== want.data_byte || rsp_kind !== want.kind ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= MaxReported)
                  $display("ERROR: expected data %02h kind %0d last %0d, got %02h %0d %0d",
                           want.data_byte, want.kind, want.last,
                           rsp_data_byte, rsp_kind, rsp_last);
            end
         end
         case (rsp_kind)
            KindExt: got_ext++;
            KindPay: got_pay++;
            default: got_status++;
         endcase
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycles, decoded_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Right after reset the parse is live with nothing to skip.
   task automatic test_stream_without_start();
      bit q[$];
      gaps_on  = 1'b0;
      rsp_mode = RspAlways;
      build_stream(q, 16'h0000, 32'd0, 0, 32'd2, 2);
      send_stream(0, 1'b0, q);
      wait_drained();
   endtask

   // Header skip of zero: the start byte carries the first hidden bit.
   task automatic test_zero_header_start();
      bit q[$];
      program_csrs(16'd0, 16'hFFFF, 1'b1);
      build_stream(q, 16'hFFFF, 32'd1, 1, 32'd1, 1);
      send_stream(cfg_header_bytes, 1'b1, q);
      wait_drained();
   endtask

   task automatic test_magic_mismatch();
      bit q[$];
      rsp_mode = RspPattern;
      program_csrs(16'd3, 16'hFFFF, 1'b1);
      build_stream(q, 16'h0000, 32'd1, 1, 32'd1, 1);
      send_stream(cfg_header_bytes, 1'b1, q);
      // idle after the error: these bytes must be ignored
      send_noise(6);
      wait_drained();
      program_csrs(16'd3, 16'h1234, 1'b0);
      build_stream(q, 16'hBEEF, 32'd0, 0, 32'd3, 3);
      send_stream(cfg_header_bytes, 1'b1, q);
      wait_drained();
   endtask

   task automatic test_empty_payload();
      bit q[$];
      rsp_mode = RspRandom;
      program_csrs(16'd2, 16'hA55A, 1'b1);
      build_stream(q, 16'hA55A, 32'd2, 2, 32'd0, 0);
      send_stream(cfg_header_bytes, 1'b1, q);
      send_noise(4);
      wait_drained();
   endtask

   // Restart mid extension (huge length) and again within the header skip.
   task automatic test_restart_mid_image();
      bit q[$];
      bit none[$];
      gaps_on = 1'b1;
      program_csrs(16'd4, 16'h0F0F, 1'b1);
      build_stream(q, 16'h0F0F, 32'h8000_0001, 2, 32'd0, 0);
      send_stream(cfg_header_bytes, 1'b1, q);
      send_stream(2, 1'b1, none);
      build_stream(q, 16'h0F0F, 32'd0, 0, 32'd2, 2);
      send_stream(cfg_header_bytes, 1'b1, q);
      wait_drained();
   endtask

   task automatic test_longest_header();
      bit q[$];
      program_csrs(16'd100, 16'($urandom), 1'b1);
      build_stream(q, cfg_magic, 32'd1, 1, 32'd1, 1);
      send_stream(cfg_header_bytes, 1'b1, q);
      wait_drained();
   endtask

   // Receiver holds off long enough for the result queue to fill and stall the input.
   task automatic test_backpressure();
      bit q[$];
      gaps_on  = 1'b0;
      rsp_mode = RspAlways;
      program_csrs(16'd1, 16'h5AA5, 1'b1);
      build_stream(q, 16'h5AA5, 32'd0, 0, 32'd12, 12);
      rsp_hold_request = 300;
      send_stream(cfg_header_bytes, 1'b1, q);
      wait_drained();
   endtask

   task automatic randomize_csrs();
      logic [15:0] hdr;
      logic [15:0] magic;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) hdr = 16'd0;
      else if (pick < 22) hdr = HeaderBytesReset;
      else hdr = 16'($urandom_range(1, 10));
      pick = $urandom_range(0, 9);
      if (pick == 0) magic = 16'h0000;
      else if (pick == 1) magic = 16'hFFFF;
      else magic = 16'($urandom);
      program_csrs(hdr, magic, $urandom_range(0, 99) < 75);
   endtask

   task automatic test_random_images();
      bit q[$];
      int unsigned pick;
      int unsigned ext_len;
      int unsigned pay_len;
      int unsigned keep;
      int unsigned start_count;
      logic [15:0] magic;
      start_count = image_bytes;
      randomize_csrs();
      while (image_bytes - start_count < RandomItems) begin
         gaps_on  = $urandom_range(0, 9) < 7;
         rsp_mode = rsp_mode_type'($urandom_range(0, 2));
         ext_len  = $urandom_range(0, 3);
         pay_len  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         pick     = $urandom_range(0, 99);
         if (pick < 60) begin
            build_stream(q, cfg_magic, ext_len, ext_len, pay_len, pay_len);
            send_stream(cfg_header_bytes, 1'b1, q);
         end else if (pick < 72) begin
            magic = cfg_magic ^ 16'($urandom_range(1, 16'hFFFF));
            build_stream(q, magic, ext_len, ext_len, pay_len, pay_len);
            send_stream(cfg_header_bytes, 1'b1, q);
         end else if (pick < 84) begin
            // cut the image short; the next start restarts the parse
            build_stream(q, cfg_magic, ext_len, ext_len, pay_len, pay_len);
            keep = $urandom_range(0, q.size() - 1);
            while (q.size() > keep) void'(q.pop_back());
            send_stream(cfg_header_bytes, 1'b1, q);
         end else if (pick < 92) begin
            send_noise($urandom_range(1, 10));
         end else begin
            wait_drained();
            randomize_csrs();
         end
      end
      wait_drained();
   endtask

   initial begin : main_seq
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_stream_without_start();
      test_zero_header_start();
      test_magic_mismatch();
      test_empty_payload();
      test_restart_mid_image();
      test_longest_header();
      test_backpressure();
      test_random_images();
      drop_req();
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Run covered %0d carrier bytes in %0d images, %0d register writes",
               bytes_sent, images_sent, csr_writes);
      $display("Results checked: %0d payload, %0d extension, %0d status",
               got_pay, got_ext, got_status);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
